### rtl/srad_pkg.sv
package srad_pkg;

    localparam int ADDR_W      = 10;
    localparam int BYTE_W      = 8;
    localparam int SHORT_DEPTH = 64;
    localparam int SHORT_AW    = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = 1;
    localparam int QUEUE_CW    = 2;

    localparam logic [BYTE_W-1:0] LONG_FLAG_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ZERO_BYTE      = 8'h00;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_LONG2 = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_DONE  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0,
        CMD_SWR  = 3'd1,
        CMD_SRD  = 3'd2,
        CMD_LWR  = 3'd3,
        CMD_LRD  = 3'd4
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
        logic                long_acc;
    } cmd_t;

endpackage

### rtl/srad_ram.sv
module srad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/srad_front.sv
module srad_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                frame_start,
    output srad_pkg::cmd_t      cmd
);

    import srad_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               wr_reg, wr_next;
    logic               long_reg, long_next;
    cmd_op_t            op;

    always_comb begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        wr_next    = wr_reg;
        long_next  = long_reg;
        op         = CMD_NONE;
        if (frame_start) begin
            if ((rx_byte & LONG_FLAG_MASK) == ZERO_BYTE) begin
                addr_next  = {4'b0000, rx_byte[6:1]};
                wr_next    = rx_byte[0];
                long_next  = 1'b0;
                phase_next = PH_DATA;
            end else begin
                addr_next  = {rx_byte[6:0], 3'b000};
                wr_next    = 1'b0;
                long_next  = 1'b1;
                phase_next = PH_LONG2;
            end
        end else begin
            unique case (phase_reg)
                PH_LONG2: begin
                    addr_next  = {addr_reg[ADDR_W-1:3], rx_byte[7:5]};
                    wr_next    = rx_byte[4];
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    if (long_reg) begin
                        op = wr_reg ? CMD_LWR : CMD_LRD;
                    end else begin
                        op = wr_reg ? CMD_SWR : CMD_SRD;
                    end
                    phase_next = PH_DONE;
                end
                PH_IDLE, PH_DONE: begin
                    phase_next = phase_reg;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            addr_reg  <= '0;
            wr_reg    <= 1'b0;
            long_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            wr_reg    <= wr_next;
            long_reg  <= long_next;
        end
    end

    assign cmd.op       = op;
    assign cmd.addr     = addr_reg;
    assign cmd.data     = rx_byte;
    assign cmd.long_acc = (phase_next == PH_IDLE) ? 1'b0 : long_next;

endmodule

### rtl/srad_queue.sv
module srad_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  srad_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output srad_pkg::cmd_t  head_cmd
);

    import srad_pkg::*;

    cmd_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0]   wr_ptr_reg;
    logic [QUEUE_PW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign full      = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### rtl/srad_back.sv
module srad_back #(
    parameter int LONG_DEPTH = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  srad_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_tx_byte,
    output logic            m_read_valid,
    output logic            m_write_done,
    output logic            m_long_access
);

    import srad_pkg::*;

    localparam int LAW = (LONG_DEPTH > 1) ? $clog2(LONG_DEPTH) : 1;

    logic                    issue;
    logic                    in_range;
    logic                    s_we, s_re, l_we, l_re;
    logic [BYTE_W-1:0]       s_rdata, l_rdata;
    logic [SHORT_DEPTH-1:0]  s_vld_reg;
    logic                    s_hit;

    logic                    s1_valid_reg;
    cmd_op_t                 s1_op_reg;
    logic                    s1_long_reg;
    logic                    s1_hit_reg;

    assign issue    = cmd_valid && (!s1_valid_reg || m_ready);
    assign cmd_pop  = issue;
    assign in_range = ({1'b0, cmd.addr} < (ADDR_W + 1)'(LONG_DEPTH));
    assign s_hit    = s_vld_reg[cmd.addr[SHORT_AW-1:0]];

    assign s_we = issue && (cmd.op == CMD_SWR);
    assign s_re = issue && (cmd.op == CMD_SRD);
    assign l_we = issue && (cmd.op == CMD_LWR) && in_range;
    assign l_re = issue && (cmd.op == CMD_LRD) && in_range;

    srad_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SHORT_DEPTH)
    ) u_short_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (cmd.addr[SHORT_AW-1:0]),
        .wdata (cmd.data),
        .re    (s_re),
        .raddr (cmd.addr[SHORT_AW-1:0]),
        .rdata (s_rdata)
    );

    srad_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LONG_DEPTH)
    ) u_long_ram (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (cmd.addr[LAW-1:0]),
        .wdata (cmd.data),
        .re    (l_re),
        .raddr (cmd.addr[LAW-1:0]),
        .rdata (l_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_vld_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_we) begin
                s_vld_reg[cmd.addr[SHORT_AW-1:0]] <= 1'b1;
            end
            if (issue) begin
                s1_valid_reg <= 1'b1;
            end else if (m_ready) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_op_reg   <= cmd.op;
            s1_long_reg <= cmd.long_acc;
            case (cmd.op)
                CMD_LWR, CMD_LRD: s1_hit_reg <= in_range;
                default:          s1_hit_reg <= s_hit;
            endcase
        end
    end

    always_comb begin
        m_tx_byte    = ZERO_BYTE;
        m_read_valid = 1'b0;
        m_write_done = 1'b0;
        case (s1_op_reg)
            CMD_SRD: begin
                m_read_valid = 1'b1;
                m_tx_byte    = s1_hit_reg ? s_rdata : ZERO_BYTE;
            end
            CMD_LRD: begin
                m_read_valid = 1'b1;
                m_tx_byte    = s1_hit_reg ? l_rdata : ZERO_BYTE;
            end
            CMD_SWR: m_write_done = 1'b1;
            CMD_LWR: m_write_done = s1_hit_reg;
            default: m_write_done = 1'b0;
        endcase
    end

    assign m_valid       = s1_valid_reg;
    assign m_long_access = s1_long_reg;

    a_no_issue_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> (!s1_valid_reg || m_ready))
        else $error("Back end issued a word while the output was stalled.");

    a_read_or_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_read_valid && m_write_done))
        else $error("A result word reports both a read and a write.");

    a_long_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        l_we |=> (m_valid && m_write_done && m_long_access))
        else $error("A long write did not report write done on the next result word.");

endmodule

### rtl/spi_register_access_decoder_unit.sv
// Channel  Direction  Handshake            Payload
// s_       in         s_valid / s_ready    s_rx_byte, s_frame_start
// m_       out        m_valid / m_ready    m_tx_byte, m_read_valid, m_write_done, m_long_access
//
// One word is accepted per cycle while the queue is not full (s_ready high).
// Each word passes the front decoder, a two-entry queue and the memory read stage to its result.
// Synchronous active-low reset clears the decoder state and the short register valid bits.
// A stalled result output holds back the queue only; input stalls when the queue is full.
module spi_register_access_decoder_unit #(
    parameter int LONG_DEPTH = 1024
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_frame_start,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_read_valid,
    output logic       m_write_done,
    output logic       m_long_access
);

    import srad_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic accept;
    logic q_full;
    logic q_not_empty;
    logic q_pop;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    srad_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .rx_byte     (s_rx_byte),
        .frame_start (s_frame_start),
        .cmd         (front_cmd)
    );

    srad_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    srad_back #(
        .LONG_DEPTH (LONG_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_not_empty),
        .cmd           (head_cmd),
        .cmd_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tx_byte     (m_tx_byte),
        .m_read_valid  (m_read_valid),
        .m_write_done  (m_write_done),
        .m_long_access (m_long_access)
    );

endmodule
